### hdl/slwd_pkg.sv
// ----------------------------------------------------------------------------
// slwd_pkg
// Shared widths, register indexes, reset values and types of the stable
// level window detector.
// ----------------------------------------------------------------------------
`default_nettype none

package slwd_pkg;

   // width of a sample, a difference and every threshold register
   localparam int unsigned VALUE_W = 12;

   // default window length
   localparam int unsigned SLWD_DEPTH = 4;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_HIGH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_LOW    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIPPLE_LIMIT = 2'd2;

   // register reset values
   localparam logic [VALUE_W-1:0] LEVEL_HIGH_RST   = 12'd3900;
   localparam logic [VALUE_W-1:0] LEVEL_LOW_RST    = 12'd3700;
   localparam logic [VALUE_W-1:0] RIPPLE_LIMIT_RST = 12'd60;

   // thresholds seen by every cell of the window
   typedef struct packed {
      logic [VALUE_W-1:0] level_high;
      logic [VALUE_W-1:0] ripple_limit;
   } slwd_thresh_type;

   // one window entry handed from cell to cell
   typedef struct packed {
      logic [VALUE_W-1:0] level;
      logic [VALUE_W-1:0] ripple;
   } slwd_entry_type;

endpackage

`default_nettype wire

### hdl/slwd_if.sv
// ----------------------------------------------------------------------------
// slwd_req_if / slwd_rsp_if
// Valid/ready channels carrying one sample in and one lamp decision out.
// ----------------------------------------------------------------------------
`default_nettype none

interface slwd_req_if
   import slwd_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface slwd_rsp_if;
   logic valid;
   logic ready;
   logic lamp_on;

   modport source (output valid, output lamp_on, input ready);
   modport sink   (input valid, input lamp_on, output ready);
endinterface

`default_nettype wire

### hdl/slwd_cell.sv
// ----------------------------------------------------------------------------
// slwd_cell
// One window entry: holds a sample and its difference, passes them to the
// next cell on a shift and flags whether the entry is high and steady.
// ----------------------------------------------------------------------------
`default_nettype none

module slwd_cell
   import slwd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            shift,
   input  wire slwd_entry_type  entry_in,
   input  wire slwd_thresh_type thresh,
   output slwd_entry_type       entry_out,
   output logic                 entry_ok
);

   slwd_entry_type entry_ff;
   slwd_entry_type entry_in_d;

   // take the neighbor's entry on a shift, otherwise hold
   always_comb begin
      entry_in_d = shift ? entry_in : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in_d;
   end

   // entry qualifies when bright enough and ripple within limit
   assign entry_ok  = (entry_ff.level >= thresh.level_high) &&
                      (entry_ff.ripple <= thresh.ripple_limit);
   assign entry_out = entry_ff;

endmodule

`default_nettype wire

### hdl/stable_level_window_detector.sv
// ----------------------------------------------------------------------------
// stable_level_window_detector
// Qualifies a lamp as steadily on from a window of light-sensor samples held
// in a chain of cells, with a one-entry result register on the output.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+--------------------------------
//  req_chan | in        | sample  [11:0] unsigned
//  rsp_chan | out       | lamp_on [0]
//  csr_*    | in        | csr_index [1:0], csr_wdata [11:0]
//
// One item per cycle sustained while the result channel is ready; a result is
// offered once its item moves from the pending stage to the result register.
// The cell chain shifts at an input transfer above the low level; the decision
// over all cells is formed when the pending item moves to the result register.
// Reset loads the register defaults and clears the previous sample, the fill
// count and both stage flags.
// A stalled result register holds the pending item, which holds the input.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_level_window_detector
   import slwd_pkg::*;
#(
   parameter int unsigned DEPTH = SLWD_DEPTH
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   slwd_req_if.sink                    req_chan,
   slwd_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [VALUE_W-1:0]     csr_wdata
);

   localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

   // configuration registers
   logic [VALUE_W-1:0] level_high_ff, level_high_in;
   logic [VALUE_W-1:0] level_low_ff, level_low_in;
   logic [VALUE_W-1:0] ripple_limit_ff, ripple_limit_in;

   // control and data state
   logic [VALUE_W-1:0] prev_sample_ff, prev_sample_in;
   logic [COUNT_W-1:0] fill_count_ff, fill_count_in;
   logic               pending_ff, pending_in;
   logic               out_valid_ff, out_valid_in;
   logic               lamp_on_ff, lamp_on_in;

   logic               req_xfer;
   logic               advance;
   logic               above_low;
   logic [VALUE_W-1:0] diff;
   slwd_thresh_type    thresh;
   slwd_entry_type     new_entry;
   slwd_entry_type     chain [DEPTH+1];
   logic [DEPTH-1:0]   cell_ok;

   // configuration writes, unknown indexes ignored
   always_comb begin
      level_high_in   = level_high_ff;
      level_low_in    = level_low_ff;
      ripple_limit_in = ripple_limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LEVEL_HIGH:   level_high_in   = csr_wdata;
            CSR_LEVEL_LOW:    level_low_in    = csr_wdata;
            CSR_RIPPLE_LIMIT: ripple_limit_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // pending item moves to the result register when it is free or drains
   assign advance          = pending_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !pending_ff || advance;
   assign req_xfer         = req_chan.valid && req_chan.ready;

   // absolute difference against the previous sample
   assign diff      = (req_chan.sample >= prev_sample_ff) ?
                      (req_chan.sample - prev_sample_ff) :
                      (prev_sample_ff - req_chan.sample);
   assign above_low = req_chan.sample > level_low_ff;

   assign new_entry.level  = req_chan.sample;
   assign new_entry.ripple = diff;
   assign thresh.level_high   = level_high_ff;
   assign thresh.ripple_limit = ripple_limit_ff;

   // window chain, newest entry enters at cell zero
   assign chain[0] = new_entry;
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      slwd_cell u_cell (
         .clock     (clock),
         .shift     (req_xfer && above_low),
         .entry_in  (chain[i]),
         .thresh    (thresh),
         .entry_out (chain[i+1]),
         .entry_ok  (cell_ok[i])
      );
   end

   // previous sample, fill count and stage flags
   always_comb begin
      prev_sample_in = prev_sample_ff;
      fill_count_in  = fill_count_ff;
      pending_in     = pending_ff;
      out_valid_in   = out_valid_ff;
      lamp_on_in     = lamp_on_ff;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         pending_in   = 1'b0;
         out_valid_in = 1'b1;
         lamp_on_in   = (fill_count_ff == COUNT_FULL) && (&cell_ok);
      end
      if (req_xfer) begin
         pending_in     = 1'b1;
         prev_sample_in = req_chan.sample;
         if (!above_low) begin
            fill_count_in = '0;
         end else if (fill_count_ff != COUNT_FULL) begin
            fill_count_in = fill_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_high_ff   <= LEVEL_HIGH_RST;
         level_low_ff    <= LEVEL_LOW_RST;
         ripple_limit_ff <= RIPPLE_LIMIT_RST;
         prev_sample_ff  <= '0;
         fill_count_ff   <= '0;
         pending_ff      <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         level_high_ff   <= level_high_in;
         level_low_ff    <= level_low_in;
         ripple_limit_ff <= ripple_limit_in;
         prev_sample_ff  <= prev_sample_in;
         fill_count_ff   <= fill_count_in;
         pending_ff      <= pending_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      lamp_on_ff <= lamp_on_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.lamp_on = lamp_on_ff;

endmodule

`default_nettype wire
